FILE: src/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

FILE: src/sm3_pkg.sv
package sm3_pkg;

	localparam logic [31:0] T_LOW    = 32'h79CC4519;
	localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
	localparam logic [7:0]  PAD_MARK = 8'h80;

	localparam logic [31:0] IV [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	// Word source for the block buffer write.
	typedef enum logic [2:0] {
		SRC_WORD,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN_HI,
		SRC_LEN_LO
	} src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       push;      // write one word into the block buffer
		src_t       src;
		logic       add_count; // add this word's bits to the length
		logic       load;      // copy block and chaining value into round regs
		logic       round;     // execute one compression round
		logic       fold;      // xor round regs into chaining value
		logic       restart;   // reset chaining value and length
		logic       shift_out; // advance digest readout by one word
	} sm3_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic [3:0] word_pos;
		logic [5:0] round_idx;
	} sm3_stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

FILE: src/sm3_datapath.sv
module sm3_datapath import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sm3_cmd_t    cmd,
	input  logic [31:0] word_in,
	input  logic [2:0]  nbytes,
	output sm3_stat_t   stat,
	output logic [31:0] digest_out
);

	logic [31:0] blk_q [16];
	logic [31:0] w_q [16];
	logic [31:0] r_q [8];
	logic [31:0] cv_q [8];
	logic [63:0] count_q;
	logic [3:0]  pos_q;
	logic [5:0]  j_q;

	logic [31:0] keep, push_val, new_w, tt1, tt2, ss1, ss2, a12, ff, gg, t, wj;
	logic [63:0] count_next;

	always_comb begin
		// A full final word keeps none of the input here: the marker fills a word of its own.
		keep = (nbytes == 3'd0 || nbytes[2]) ? 32'h0 :
			(32'hFFFFFFFF << (6'd32 - {nbytes, 3'b000}));
		count_next = count_q + {58'd0, nbytes, 3'b000};
		case (cmd.src)
			SRC_WORD:   push_val = word_in;
			SRC_PAD:    push_val = (word_in & keep) |
				({PAD_MARK, 24'd0} >> {nbytes[1:0], 3'b000});
			SRC_ZERO:   push_val = 32'd0;
			SRC_LEN_HI: push_val = count_q[63:32];
			SRC_LEN_LO: push_val = count_q[31:0];
			default:    push_val = 32'd0;
		endcase
		wj  = w_q[0];
		t   = (j_q < 6'd16) ? T_LOW : T_HIGH;
		a12 = rotl(r_q[0], 5'd12);
		ss1 = rotl(a12 + r_q[4] + rotl(t, j_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (j_q < 6'd16) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + (wj ^ w_q[4]);
		tt2 = gg + r_q[7] + ss1 + wj;
		new_w = p1(wj ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
	end

	// The window is a shift line: position 0 always holds word j.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			blk_q[pos_q] <= push_val;
		end
		if (cmd.load) begin
			w_q <= blk_q;
			r_q <= cv_q;
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= new_w;
			r_q[0] <= tt1;
			r_q[1] <= r_q[0];
			r_q[2] <= rotl(r_q[1], 5'd9);
			r_q[3] <= r_q[2];
			r_q[4] <= p0(tt2);
			r_q[5] <= r_q[4];
			r_q[6] <= rotl(r_q[5], 5'd19);
			r_q[7] <= r_q[6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q    <= IV;
			count_q <= '0;
			pos_q   <= '0;
			j_q     <= '0;
		end else begin
			if (cmd.push) pos_q <= pos_q + 4'd1;
			if (cmd.add_count) count_q <= count_next;
			if (cmd.load) j_q <= '0;
			else if (cmd.round) j_q <= j_q + 6'd1;
			if (cmd.restart) begin
				cv_q    <= IV;
				count_q <= '0;
			end else if (cmd.fold) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ r_q[i];
			end else if (cmd.shift_out) begin
				for (int i = 0; i < 7; i++) cv_q[i] <= cv_q[i+1];
				cv_q[7] <= cv_q[0];
			end
		end
	end

	assign stat.word_pos  = pos_q;
	assign stat.round_idx = j_q;
	assign digest_out     = cv_q[0];

endmodule

FILE: src/sm3_ctrl.sv
module sm3_ctrl import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [2:0]  in_bytes,
	input  logic        in_last,
	output logic        in_stall,
	output logic [2:0]  nbytes,
	input  sm3_stat_t   stat,
	output sm3_cmd_t    cmd,
	output logic        out_valid,
	output logic        out_last,
	input  logic        out_stall
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PAD_FULL, ST_ZERO, ST_LEN_HI, ST_LEN_LO,
		ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT
	} state_t;

	state_t     state_q, ret_q;
	logic [2:0] nb_q;
	logic [2:0] cnt_q;
	logic       go_compress;
	state_t     after;
	logic       accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_last  = (cnt_q == 3'd7);

	always_comb begin
		nbytes = (state_q == ST_IDLE) ? ((in_bytes > 3'd4) ? 3'd4 : in_bytes) : nb_q;
		if (state_q == ST_IDLE && !in_last) nbytes = 3'd4;
		cmd = '0;
		cmd.src = SRC_WORD;
		go_compress = (stat.word_pos == 4'd15);
		after = ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				cmd.push = accept;
				cmd.add_count = accept;
				if (accept && in_last && nbytes != 3'd4) cmd.src = SRC_PAD;
				if (!in_last) after = ST_IDLE;
				else if (nbytes == 3'd4) after = ST_PAD_FULL;
				else after = (stat.word_pos == 4'd13) ? ST_LEN_HI : ST_ZERO;
			end
			ST_PAD_FULL: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_PAD;
				after = (stat.word_pos == 4'd13) ? ST_LEN_HI : ST_ZERO;
			end
			ST_ZERO: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_ZERO;
				after = (stat.word_pos == 4'd13) ? ST_LEN_HI : ST_ZERO;
			end
			ST_LEN_HI: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_LEN_HI;
				after = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_LEN_LO;
			end
			ST_LOAD:  cmd.load  = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_FOLD:  cmd.fold  = 1'b1;
			ST_OUT: begin
				cmd.shift_out = !out_stall;
				cmd.restart   = !out_stall && out_last;
			end
			default: ;
		endcase
	end

	// Every push that fills word 15 detours through a compression.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			nb_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (accept) nb_q <= nbytes;
			case (state_q)
				ST_LOAD:  state_q <= ST_ROUND;
				ST_ROUND: if (stat.round_idx == 6'd63) state_q <= ST_FOLD;
				ST_FOLD:  state_q <= ret_q;
				ST_OUT: begin
					if (!out_stall) begin
						cnt_q <= cnt_q + 3'd1;
						if (out_last) state_q <= ST_IDLE;
					end
				end
				ST_LEN_LO: begin
					ret_q   <= ST_OUT;
					state_q <= ST_LOAD;
				end
				default: begin
					if (cmd.push) begin
						if (go_compress) begin
							ret_q   <= after;
							state_q <= ST_LOAD;
						end else begin
							state_q <= after;
						end
					end
				end
			endcase
		end
	end

endmodule

FILE: src/sm3_hash_engine.sv
// SM3 hash engine. Message words (big-endian, first byte in bits 31:24) enter one
// request per cycle while the 16-word block buffer fills; after the request that
// fills the block, input is stalled while the engine loads, runs 64 rounds through
// one shared round unit and folds, so the sustained cost per word is set by
// the single round unit. On the word flagged last_word the engine pads the
// message itself (0x80 marker, zeros, 64-bit bit length), pushing each padding
// word and running one or two compressions, and then emits eight digest words,
// most significant first, with digest_last on the eighth. The next message
// starts fresh after the eighth digest word is taken. No clearing pass is needed.
`include "assert_macros.svh"
module sm3_hash_engine import sm3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        digest_last
);

	sm3_cmd_t   cmd;
	sm3_stat_t  stat;
	logic [2:0] nbytes;

	sm3_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid, .in_bytes(valid_bytes), .in_last(last_word), .in_stall,
		.nbytes, .stat, .cmd,
		.out_valid, .out_last(digest_last), .out_stall
	);

	sm3_datapath u_dp (
		.clk, .arst_n, .cmd,
		.word_in(message_word), .nbytes, .stat,
		.digest_out(digest_word)
	);

	// Input is refused whenever results are being presented.
	`ASSERT_IMPLY(a_stall_out, clk, arst_n, out_valid, in_stall)
	// A taken last digest word returns the engine to accepting input.
	`ASSERT_NEXT(a_done, clk, arst_n, out_valid && digest_last && !out_stall, !in_stall)
	// A held result keeps its data.
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, $stable(digest_word))

endmodule

FILE: test/sm3_hash_engine_tb.sv
`timescale 1ns / 100ps
module sm3_hash_engine_tb;
	import sm3_pkg::*;

	localparam int RANDOM_WORDS  = 250;
	localparam int IDLE_LIMIT    = 20000;
	localparam int DRAIN_CYCLES  = 200;
	localparam int LONG_HOLD     = 600;

	// Scoreboard: predicts the digest of each message and checks the digest words in order.
	class digest_scoreboard;
		logic [31:0] chain [8];
		logic [31:0] block [16];
		logic [63:0] bit_len;
		int unsigned fill;
		logic [32:0] pending [$];
		int unsigned mismatches;

		function new();
			restart();
			mismatches = 0;
		endfunction

		function void restart();
			foreach (chain[i]) chain[i] = IV[i];
			bit_len = '0;
			fill = 0;
		endfunction

		function logic [31:0] rol(logic [31:0] x, int unsigned n);
			n = n % 32;
			if (n == 0) return x;
			return (x << n) | (x >> (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] r [8];
			logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, nx, x;
			foreach (w[i]) w[i] = block[i];
			foreach (r[i]) r[i] = chain[i];
			for (int j = 0; j < 64; j++) begin
				tj = (j < 16) ? T_LOW : T_HIGH;
				a12 = rol(r[0], 12);
				ss1 = rol(a12 + r[4] + rol(tj, j), 7);
				ss2 = ss1 ^ a12;
				if (j < 16) begin
					ff = r[0] ^ r[1] ^ r[2];
					gg = r[4] ^ r[5] ^ r[6];
				end else begin
					ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
					gg = (r[4] & r[5]) | (~r[4] & r[6]);
				end
				tt1 = ff + r[3] + ss2 + (w[j % 16] ^ w[(j + 4) % 16]);
				tt2 = gg + r[7] + ss1 + w[j % 16];
				r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
				r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4];
				r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
				x = w[j % 16] ^ w[(j + 7) % 16] ^ rol(w[(j + 13) % 16], 15);
				nx = x ^ rol(x, 15) ^ rol(x, 23);
				w[j % 16] = nx ^ rol(w[(j + 3) % 16], 7) ^ w[(j + 10) % 16];
			end
			foreach (chain[i]) chain[i] ^= r[i];
		endfunction

		function void add_word(logic [31:0] w);
			block[fill] = w;
			fill = (fill + 1) % 16;
			if (fill == 0) compress();
		endfunction

		// Notes one accepted request and queues the digest if it ends a message.
		function void note_request(logic [31:0] word, logic [2:0] nbytes, logic last);
			int unsigned n;
			logic [31:0] keep;
			if (!last) begin
				bit_len += 32;
				add_word(word);
				return;
			end
			n = (nbytes > 4) ? 4 : nbytes;
			bit_len += 8 * n;
			if (n == 4) begin
				add_word(word);
				add_word({PAD_MARK, 24'h0});
			end else begin
				keep = (n == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * n));
				add_word((word & keep) | (32'(PAD_MARK) << (24 - 8 * n)));
			end
			while (fill != 14) add_word('0);
			add_word(bit_len[63:32]);
			add_word(bit_len[31:0]);
			for (int i = 0; i < 8; i++) pending.push_back({i == 7, chain[i]});
			restart();
		endfunction

		function void check_digest(logic [31:0] word, logic last);
			logic [32:0] exp_item;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected digest word %h last %b", word, last);
				return;
			end
			exp_item = pending.pop_front();
			if (exp_item[31:0] !== word || exp_item[32] !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Digest mismatch: expected %h/%b, got %h/%b",
						exp_item[31:0], exp_item[32], word, last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] message_word;
	logic [2:0]  valid_bytes;
	logic        last_word;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic        digest_last;

	digest_scoreboard sb;
	bit calm_phase;     // no idling on either side once this is set
	bit hold_request;   // asks the receiver for one long stall
	int unsigned idle_cycles;

	sm3_hash_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.message_word(message_word), .valid_bytes(valid_bytes), .last_word(last_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .digest_last(digest_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Both handshakes are sampled at the rising edge, before the new drive values land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(message_word, valid_bytes, last_word);
			if (out_valid && !out_stall)
				sb.check_digest(digest_word, digest_last);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// The receiver stalls in random bursts, plus one long hold-off when asked.
	initial begin
		int unsigned burst;
		out_stall = 1'b1;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 14);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Offers one request and holds it until the block takes it.
	task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic last);
		if (!calm_phase && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		message_word <= w;
		valid_bytes  <= n;
		last_word    <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic pause_sender();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// A message of body_words full words and a final word with the given byte count.
	task automatic send_message(input int body_words, input logic [2:0] n);
		for (int i = 0; i < body_words; i++)
			send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
		send_word($urandom, n, 1'b1);
	endtask

	initial begin
		int sent;
		int len;
		sb = new();
		calm_phase = 1'b0;
		hold_request = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		message_word = '0;
		valid_bytes = '0;
		last_word = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, every byte count including the values clamped to four,
		// extreme field values, and lengths around the padding boundary.
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'hFFFFFFFF, 3'd0, 1'b1);
		send_word(32'hFFFFFFFF, 3'd1, 1'b1);
		send_word(32'hFFFFFFFF, 3'd2, 1'b1);
		send_word(32'h61626300, 3'd3, 1'b1);
		send_word(32'hFFFFFFFF, 3'd4, 1'b1);
		send_word(32'h00000000, 3'd5, 1'b1);
		send_word(32'hFFFFFFFF, 3'd6, 1'b1);
		send_word(32'hA5A5A5A5, 3'd7, 1'b1);
		send_message(12, 3'd4);
		send_message(13, 3'd3);
		pause_sender();

		// The receiver holds off while the sender keeps offering, so input stalls behind the held digest.
		hold_request = 1'b1;
		sent = 0;
		while (sent < 60) begin
			len = $urandom_range(0, 6);
			send_message(len, 3'($urandom_range(0, 7)));
			sent += len + 1;
		end
		pause_sender();

		// Random messages, mostly short, a few spanning several blocks.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if (sent > RANDOM_WORDS * 3 / 4) calm_phase = 1'b1;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 15);
			send_message(len, 3'($urandom_range(0, 7)));
			sent += len + 1;
		end
		in_valid <= 1'b0;

		calm_phase = 1'b1;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sm3_hash_engine.f
+incdir+src
src/sm3_pkg.sv
src/sm3_datapath.sv
src/sm3_ctrl.sv
src/sm3_hash_engine.sv
test/sm3_hash_engine_tb.sv
